// ===== src/krt_pkg.sv =====
// shared types, codes and constants for the keyed record table
package krt_pkg;

    localparam int CNT_W = 6;

    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_CLEAR  = 3'd1;
    localparam logic [2:0] REQ_HEADER = 3'd2;
    localparam logic [2:0] REQ_ITEM   = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_COUNT  = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    localparam logic [15:0] HDR_ERASED = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] key;
        logic [15:0] value;
        logic [31:0] image_word;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      out_word;
        logic [CNT_W-1:0] entries_used;
        logic             last;
    } t_res;

    // packed so that the 32-bit image is value<<16 | key
    typedef struct packed {
        logic [15:0] value;
        logic [15:0] key;
    } t_rec;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic [CNT_W-1:0] sel;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DUMP
    } t_state;

endpackage

// ===== src/krt_cell.sv =====
// one record cell of the ring: direct load at its own position or shift from its neighbor
module krt_cell #(
    parameter int POS = 0
) (
    input  logic               i_clk,
    input  krt_pkg::t_cell_ctl i_ctl,
    input  krt_pkg::t_rec      i_ld_rec,
    input  krt_pkg::t_rec      i_prev,
    output krt_pkg::t_rec      o_rec
);

    krt_pkg::t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.sel == krt_pkg::CNT_W'(POS))) begin
            r_rec <= i_ld_rec;
        end else if (i_ctl.shift) begin
            r_rec <= i_prev;
        end
    end

    assign o_rec = r_rec;

endmodule

// ===== src/keyed_record_table_with_image.sv =====
// keyed record table: ring of record cells with search, append, image load and dump
//
//  channel   | signals                  | handshake
//  ----------+--------------------------+---------------------------------------
//  request   | start, busy, i_req       | beat taken when start=1 and busy=0
//  result    | o_strobe, o_res          | one cycle per beat, strobe marks it
//
//  clear, header, item, unknown and empty-table dump leave the block idle; result in the next cycle
//  write and a dump of a non-empty table keep the block busy while the ring turns once through cell 0
//  a dump gives its count word, then one record a cycle as it passes cell 0
//  synchronous active-low reset empties the table; the record cells are not cleared
//  results cannot be held off, so results leave as soon as they are made
module keyed_record_table_with_image #(
    parameter int ENTRIES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  krt_pkg::t_req i_req,
    output logic          o_strobe,
    output krt_pkg::t_res o_res
);

    localparam int CNT_W = krt_pkg::CNT_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [CNT_W-1:0] ENT_C    = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    krt_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_pend, n_pend;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_found, n_found;
    logic               r_strobe, n_strobe;
    krt_pkg::t_res      r_res, n_res;
    logic [15:0]        r_key, r_val;

    krt_pkg::t_rec      c_rec [ENTRIES];
    krt_pkg::t_rec      tail;
    krt_pkg::t_rec      ld_rec;
    krt_pkg::t_cell_ctl ctl;

    logic               accept;
    logic [CNT_W-1:0]   idx_ext;
    logic [15:0]        hdr_cnt;

    assign accept  = start && (r_state == krt_pkg::S_IDLE);
    assign busy    = (r_state != krt_pkg::S_IDLE);
    assign idx_ext = CNT_W'(r_idx);
    assign hdr_cnt = i_req.image_word[15:0];
    assign ld_rec  = krt_pkg::t_rec'(i_req.image_word);

    // ring: cell i takes from cell i+1, the last cell takes the (edited) record of cell 0
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == ENTRIES - 1) begin : g_tail
            krt_cell #(.POS(g)) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_ld_rec (ld_rec),
                .i_prev   (tail),
                .o_rec    (c_rec[g])
            );
        end else begin : g_mid
            krt_cell #(.POS(g)) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_ld_rec (ld_rec),
                .i_prev   (c_rec[g+1]),
                .o_rec    (c_rec[g])
            );
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pend    = r_pend;
        n_idx     = r_idx;
        n_found   = r_found;
        n_strobe  = 1'b0;
        n_res     = '0;
        ctl.shift = 1'b0;
        ctl.load  = 1'b0;
        ctl.sel   = r_count;
        tail      = c_rec[0];

        unique case (r_state)
            krt_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type)
                        krt_pkg::REQ_WRITE: begin
                            n_pend  = '0;
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_state = krt_pkg::S_SWEEP;
                        end
                        krt_pkg::REQ_CLEAR: begin
                            n_count  = '0;
                            n_pend   = '0;
                            n_strobe = 1'b1;
                            n_res    = '{krt_pkg::ST_OK, 32'd0, CNT_W'(0), 1'b1};
                        end
                        krt_pkg::REQ_HEADER: begin
                            n_count  = '0;
                            n_pend   = '0;
                            n_strobe = 1'b1;
                            n_res    = '{krt_pkg::ST_OK, 32'd0, CNT_W'(0), 1'b1};
                            if (hdr_cnt == 16'd0 || hdr_cnt == krt_pkg::HDR_ERASED) begin
                                n_res.status = krt_pkg::ST_OK;
                            end else if (hdr_cnt > 16'(ENTRIES)) begin
                                n_res.status = krt_pkg::ST_BAD_COUNT;
                            end else begin
                                n_pend = hdr_cnt[CNT_W-1:0];
                            end
                        end
                        krt_pkg::REQ_ITEM: begin
                            n_strobe = 1'b1;
                            if (r_pend == '0 || r_count >= ENT_C) begin
                                n_res = '{krt_pkg::ST_UNEXPECTED, 32'd0, r_count, 1'b1};
                            end else begin
                                ctl.load = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_pend   = r_pend - 1'b1;
                                n_res    = '{krt_pkg::ST_OK, 32'd0, r_count + 1'b1, 1'b1};
                            end
                        end
                        krt_pkg::REQ_DUMP: begin
                            n_strobe = 1'b1;
                            n_res    = '{krt_pkg::ST_OK, 32'(r_count), r_count,
                                         (r_count == '0)};
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = krt_pkg::S_DUMP;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res    = '{krt_pkg::ST_OK, 32'd0, r_count, 1'b1};
                        end
                    endcase
                end
            end
            krt_pkg::S_SWEEP: begin
                ctl.shift = 1'b1;
                n_idx     = IDX_W'(r_idx + 1'b1);
                // first matching record gets the new value, else append at the fill point
                if (idx_ext < r_count && c_rec[0].key == r_key && !r_found) begin
                    tail.value = r_val;
                    n_found    = 1'b1;
                end else if (idx_ext == r_count && !r_found && r_count < ENT_C) begin
                    tail.value = r_val;
                    tail.key   = r_key;
                end
                if (r_idx == IDX_LAST) begin
                    n_idx    = '0;
                    n_state  = krt_pkg::S_IDLE;
                    n_strobe = 1'b1;
                    if (n_found) begin
                        n_res = '{krt_pkg::ST_OK, 32'd0, r_count, 1'b1};
                    end else if (r_count >= ENT_C) begin
                        n_res = '{krt_pkg::ST_FULL, 32'd0, r_count, 1'b1};
                    end else begin
                        n_count = r_count + 1'b1;
                        n_res   = '{krt_pkg::ST_OK, 32'd0, r_count + 1'b1, 1'b1};
                    end
                end
            end
            krt_pkg::S_DUMP: begin
                ctl.shift = 1'b1;
                n_idx     = IDX_W'(r_idx + 1'b1);
                if (idx_ext < r_count) begin
                    n_strobe = 1'b1;
                    n_res    = '{krt_pkg::ST_OK, 32'(c_rec[0]), r_count,
                                 (idx_ext == r_count - 1'b1)};
                end
                // keep turning until every record is back in its home cell
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = krt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = krt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= krt_pkg::S_IDLE;
            r_count  <= '0;
            r_pend   <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_idx    <= n_idx;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_key <= i_req.key;
            r_val <= i_req.value;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ENT_C)
        else $error("record count above capacity");

    a_pend_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {1'b0, r_pend}) <= {1'b0, ENT_C})
        else $error("pending items overflow the table");

    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krt_pkg::S_SWEEP && r_idx != IDX_LAST) |=> !r_strobe)
        else $error("result beat in the middle of a write sweep");

    a_dump_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == krt_pkg::REQ_DUMP)
        |=> (r_strobe && r_res.out_word == 32'($past(r_count))))
        else $error("dump count beat missing");

endmodule

// ===== bench/tb_keyed_record_table_with_image.sv =====
// testbench for the keyed record table: directed table, random load/write/dump traffic, self-check
module tb_keyed_record_table_with_image;

    localparam int ENTRIES         = 32;
    localparam int ITEMS_TARGET    = 160;
    localparam int WATCHDOG_CYCLES = 20 * (ENTRIES + 8);
    localparam int TAIL_CYCLES     = ENTRIES + 8;

    // request codes the block answers with a plain ok
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        krt_pkg::t_req req;
        bit            typed;
        krt_pkg::t_res res;
    } t_dir_row;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    krt_pkg::t_req i_req   = '0;
    logic          busy;
    logic          o_strobe;
    krt_pkg::t_res o_res;

    // predicted table contents
    logic [15:0] tbl_key [ENTRIES];
    logic [15:0] tbl_val [ENTRIES];
    int unsigned tbl_count;
    int unsigned load_left;

    krt_pkg::t_res step_res[$];
    krt_pkg::t_res due_res[$];
    t_dir_row      dir_rows[$];
    logic [15:0]   key_pool [8];

    int mismatches = 0;
    int items_sent;
    int quiet_left;
    int idle_cycles = 0;

    keyed_record_table_with_image #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // works out the result beats of one request and updates the predicted table
    function automatic void table_step(input krt_pkg::t_req r);
        int unsigned i;
        int unsigned hdr_n;
        bit hit;
        krt_pkg::t_res res;
        step_res.delete();
        res = '0;
        res.status = krt_pkg::ST_OK;
        res.last = 1'b1;
        case (r.req_type)
            krt_pkg::REQ_WRITE: begin
                load_left = 0;
                hit = 1'b0;
                for (i = 0; i < tbl_count; i++) begin
                    if (!hit && tbl_key[i] == r.key) begin
                        tbl_val[i] = r.value;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (tbl_count >= ENTRIES) begin
                        res.status = krt_pkg::ST_FULL;
                    end else begin
                        tbl_key[tbl_count] = r.key;
                        tbl_val[tbl_count] = r.value;
                        tbl_count++;
                    end
                end
            end
            krt_pkg::REQ_CLEAR: begin
                tbl_count = 0;
                load_left = 0;
            end
            krt_pkg::REQ_HEADER: begin
                hdr_n = 32'(r.image_word[15:0]);
                tbl_count = 0;
                load_left = 0;
                if (hdr_n == 0 || hdr_n == 32'(krt_pkg::HDR_ERASED)) begin
                    res.status = krt_pkg::ST_OK;
                end else if (hdr_n > ENTRIES) begin
                    res.status = krt_pkg::ST_BAD_COUNT;
                end else begin
                    load_left = hdr_n;
                end
            end
            krt_pkg::REQ_ITEM: begin
                if (load_left == 0 || tbl_count >= ENTRIES) begin
                    res.status = krt_pkg::ST_UNEXPECTED;
                end else begin
                    tbl_key[tbl_count] = r.image_word[15:0];
                    tbl_val[tbl_count] = r.image_word[31:16];
                    tbl_count++;
                    load_left--;
                end
            end
            krt_pkg::REQ_DUMP: begin
                res.out_word = tbl_count;
                res.entries_used = krt_pkg::CNT_W'(tbl_count);
                res.last = (tbl_count == 0);
                step_res.push_back(res);
                for (i = 0; i < tbl_count; i++) begin
                    res.out_word = {tbl_val[i], tbl_key[i]};
                    res.last = (i + 1 == tbl_count);
                    step_res.push_back(res);
                end
            end
            default: ;
        endcase
        if (r.req_type != krt_pkg::REQ_DUMP) begin
            res.entries_used = krt_pkg::CNT_W'(tbl_count);
            step_res.push_back(res);
        end
    endfunction

    function automatic t_dir_row mk_row(input logic [2:0] rt, input logic [15:0] k,
                                        input logic [15:0] v, input logic [31:0] w,
                                        input bit typed, input logic [1:0] st,
                                        input logic [krt_pkg::CNT_W-1:0] used);
        t_dir_row row;
        row.req = '{req_type: rt, key: k, value: v, image_word: w};
        row.typed = typed;
        row.res = '{status: st, out_word: 32'h0, entries_used: used, last: 1'b1};
        return row;
    endfunction

    function automatic krt_pkg::t_req rnd_req(input logic [2:0] rt);
        krt_pkg::t_req r;
        r.req_type = rt;
        r.key = 16'($urandom);
        r.value = 16'($urandom);
        r.image_word = $urandom;
        return r;
    endfunction

    // one request beat; start stays high afterwards until the next call or a drain
    task automatic send_req(input krt_pkg::t_req r, input bit typed,
                            input krt_pkg::t_res typed_res);
        int gap;
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            quiet_left = $urandom_range(8, 20);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 7);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        table_step(r);
        if (typed) begin
            due_res.push_back(typed_res);
        end else begin
            foreach (step_res[i]) due_res.push_back(step_res[i]);
        end
        if (r.req_type <= krt_pkg::REQ_DUMP) items_sent++;
    endtask

    task automatic send_rnd(input logic [2:0] rt);
        send_req(rnd_req(rt), 1'b0, '0);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (due_res.size() != 0) @(posedge i_clk);
    endtask

    // header then item words; a broken one is cut short by some other request
    task automatic load_sequence(input int n, input bit clean);
        krt_pkg::t_req r;
        bit cut;
        r = rnd_req(krt_pkg::REQ_HEADER);
        r.image_word[15:0] = 16'(n);
        send_req(r, 1'b0, '0);
        cut = 1'b0;
        for (int i = 0; i < n && !cut; i++) begin
            if (!clean && $urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 3))
                    0: send_rnd(krt_pkg::REQ_WRITE);
                    1: send_rnd(krt_pkg::REQ_CLEAR);
                    2: send_rnd(krt_pkg::REQ_HEADER);
                    default: send_rnd(krt_pkg::REQ_DUMP);
                endcase
                cut = 1'b1;
            end else begin
                if (!clean && $urandom_range(0, 9) == 0) send_rnd(krt_pkg::REQ_DUMP);
                send_rnd(krt_pkg::REQ_ITEM);
            end
        end
        if (!clean && $urandom_range(0, 5) == 0) send_rnd(krt_pkg::REQ_ITEM);
    endtask

    task automatic send_write(input bit from_pool);
        krt_pkg::t_req r;
        r = rnd_req(krt_pkg::REQ_WRITE);
        if (from_pool) r.key = key_pool[$urandom_range(0, 7)];
        send_req(r, 1'b0, '0);
    endtask

    // result beats are checked as they leave; nothing can hold them off
    always @(posedge i_clk) begin
        krt_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (due_res.size() == 0) begin
                $error("result beat with nothing expected: %p", o_res);
                mismatches++;
            end else begin
                want = due_res.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    mismatches++;
                end
                if (o_res.out_word !== want.out_word) begin
                    $error("out_word: expected %h, got %h", want.out_word, o_res.out_word);
                    mismatches++;
                end
                if (o_res.entries_used !== want.entries_used) begin
                    $error("entries_used: expected %0d, got %0d",
                           want.entries_used, o_res.entries_used);
                    mismatches++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_res.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("keyed_record_table_with_image test failed");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        items_sent = 0;
        quiet_left = 0;
        tbl_count = 0;
        load_left = 0;
        foreach (key_pool[i]) key_pool[i] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;

        dir_rows.push_back(mk_row(krt_pkg::REQ_DUMP, 16'h0, 16'h0, 32'h0,
                                  1, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_ITEM, 16'h0, 16'h0, 32'hDEADBEEF,
                                  1, krt_pkg::ST_UNEXPECTED, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_WRITE, 16'h0000, 16'hFFFF, 32'h0,
                                  1, krt_pkg::ST_OK, 1));
        dir_rows.push_back(mk_row(krt_pkg::REQ_WRITE, 16'hFFFF, 16'h0000, 32'hFFFFFFFF,
                                  1, krt_pkg::ST_OK, 2));
        // same key again: value replaced in place
        dir_rows.push_back(mk_row(krt_pkg::REQ_WRITE, 16'h0000, 16'hA5A5, 32'h0,
                                  1, krt_pkg::ST_OK, 2));
        dir_rows.push_back(mk_row(krt_pkg::REQ_DUMP, 16'h0, 16'h0, 32'h0,
                                  0, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(REQ_SPARE_LO, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                                  1, krt_pkg::ST_OK, 2));
        dir_rows.push_back(mk_row(REQ_SPARE_HI, 16'h0, 16'h0, 32'h0,
                                  1, krt_pkg::ST_OK, 2));
        // erased header and zero header both empty the table
        dir_rows.push_back(mk_row(krt_pkg::REQ_HEADER, 16'h0, 16'h0, 32'hFFFFFFFF,
                                  1, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_WRITE, 16'h1234, 16'h5678, 32'h0,
                                  1, krt_pkg::ST_OK, 1));
        dir_rows.push_back(mk_row(krt_pkg::REQ_HEADER, 16'hFFFF, 16'hFFFF, 32'h0,
                                  1, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_HEADER, 16'h0, 16'h0, 32'h00000021,
                                  1, krt_pkg::ST_BAD_COUNT, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_HEADER, 16'h0, 16'h0, 32'hFFFFFFFE,
                                  1, krt_pkg::ST_BAD_COUNT, 0));
        // upper header bits are ignored
        dir_rows.push_back(mk_row(krt_pkg::REQ_HEADER, 16'h0, 16'h0, 32'h00010003,
                                  1, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_ITEM, 16'h0, 16'h0, 32'hFFFF0000,
                                  1, krt_pkg::ST_OK, 1));
        // dump while a load is still open
        dir_rows.push_back(mk_row(krt_pkg::REQ_DUMP, 16'h0, 16'h0, 32'h0,
                                  0, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_ITEM, 16'h0, 16'h0, 32'h0000FFFF,
                                  1, krt_pkg::ST_OK, 2));
        // write cancels the rest of the load and keeps what arrived
        dir_rows.push_back(mk_row(krt_pkg::REQ_WRITE, 16'hFFFF, 16'h0001, 32'h0,
                                  1, krt_pkg::ST_OK, 2));
        dir_rows.push_back(mk_row(krt_pkg::REQ_ITEM, 16'h0, 16'h0, 32'h12345678,
                                  1, krt_pkg::ST_UNEXPECTED, 2));
        dir_rows.push_back(mk_row(krt_pkg::REQ_HEADER, 16'h0, 16'h0, 32'h00000001,
                                  1, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_ITEM, 16'h0, 16'h0, 32'h89ABCDEF,
                                  1, krt_pkg::ST_OK, 1));
        dir_rows.push_back(mk_row(krt_pkg::REQ_ITEM, 16'h0, 16'h0, 32'h11112222,
                                  1, krt_pkg::ST_UNEXPECTED, 1));
        dir_rows.push_back(mk_row(krt_pkg::REQ_DUMP, 16'h0, 16'h0, 32'h0,
                                  0, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                                  1, krt_pkg::ST_OK, 0));
        dir_rows.push_back(mk_row(krt_pkg::REQ_DUMP, 16'h0, 16'h0, 32'h0,
                                  1, krt_pkg::ST_OK, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // fill the table completely, then push it past capacity
        load_sequence(ENTRIES, 1'b1);
        send_write(1'b0);
        send_write(1'b1);
        send_rnd(krt_pkg::REQ_DUMP);

        while (items_sent < ITEMS_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                load_sequence(($urandom_range(0, 7) == 0) ? ENTRIES : $urandom_range(1, 6),
                              1'b0);
            end else if (pick < 60) begin
                send_write($urandom_range(0, 2) != 0);
            end else if (pick < 70) begin
                send_rnd(krt_pkg::REQ_DUMP);
            end else if (pick < 78) begin
                send_rnd(krt_pkg::REQ_CLEAR);
            end else if (pick < 86) begin
                send_rnd(krt_pkg::REQ_HEADER);
            end else if (pick < 93) begin
                send_rnd(krt_pkg::REQ_ITEM);
            end else begin
                send_rnd(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)));
            end
            if ($urandom_range(0, 15) == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_res.size() == 0) begin
            $display("keyed_record_table_with_image test passed");
        end else begin
            $display("keyed_record_table_with_image test failed");
        end
        $finish;
    end

endmodule
